### hw/rtl/pfts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfts_pkg
// Shared types, constants and register codes of the periodic frame transmit
// scheduler.
// ----------------------------------------------------------------------------
package pfts_pkg;

  localparam int unsigned FramesDefault = 4;
  localparam int unsigned CountW        = 8;
  localparam int unsigned FrameNumW     = 2;
  localparam int unsigned PrioSlots     = 4;
  localparam int unsigned EnableBits    = 4;
  localparam int unsigned PeriodRegs    = 4;
  localparam int unsigned RankW         = 3;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 8;

  typedef logic [CountW-1:0]     count_t;
  typedef logic [FrameNumW-1:0]  frame_num_t;
  typedef logic [RankW-1:0]      rank_t;
  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [CfgDataW-1:0]   cfg_data_t;

  localparam count_t CountMax      = 8'hFF;
  localparam count_t PeriodRst0    = 8'd20;
  localparam count_t PeriodRst1    = 8'd10;
  localparam count_t PeriodRstRest = 8'd255;
  localparam logic [EnableBits-1:0] EnableRst = 4'd3;
  localparam logic [2*PrioSlots-1:0] PrioRst  = 8'd225;
  localparam rank_t  RankNone      = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeriod0  = 3'd0,
    RegPeriod1  = 3'd1,
    RegPeriod2  = 3'd2,
    RegPeriod3  = 3'd3,
    RegEnable   = 3'd4,
    RegPriority = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [EnableBits-1:0]  frame_enable;
    logic [2*PrioSlots-1:0] priority_order;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic link_ready;
  } step_t;

  typedef struct packed {
    logic       frame_selected;
    frame_num_t frame_number;
    logic       frame_sent;
  } result_t;

  function automatic count_t period_reset(int unsigned idx);
    count_t val;
    val = PeriodRstRest;
    if (idx == 0) begin
      val = PeriodRst0;
    end else if (idx == 1) begin
      val = PeriodRst1;
    end
    return val;
  endfunction

endpackage

### hw/rtl/pfts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfts interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface pfts_tick_if;
  logic valid;
  logic ready;
  logic link_ready;

  modport source (output valid, output link_ready, input ready);
  modport sink (input valid, input link_ready, output ready);
endinterface

interface pfts_result_if;
  logic                  valid;
  logic                  ready;
  logic                  frame_selected;
  pfts_pkg::frame_num_t  frame_number;
  logic                  frame_sent;

  modport source (output valid, output frame_selected, output frame_number,
                  output frame_sent, input ready);
  modport sink (input valid, input frame_selected, input frame_number,
                input frame_sent, output ready);
endinterface

interface pfts_cfg_if;
  logic                valid;
  logic                ready;
  pfts_pkg::cfg_idx_t  index;
  pfts_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pfts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfts_core
// Per-frame period, due and wait state with oldest-first selection; one tick
// is evaluated and committed per step.
// ----------------------------------------------------------------------------
module pfts_core #(
  parameter int unsigned Frames = pfts_pkg::FramesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfts_pkg::step_t   step_i,
  input  pfts_pkg::count_t  period_i [Frames],
  input  pfts_pkg::ctrl_t   ctrl_i,
  output pfts_pkg::result_t result_o
);
  import pfts_pkg::*;

  localparam int unsigned SelW = $clog2(Frames + 1);
  localparam logic [SelW-1:0] SelNone = SelW'(Frames);

  count_t            pcount_q [Frames];
  count_t            pcount_d [Frames];
  count_t            wait_q   [Frames];
  count_t            wait_d   [Frames];
  logic [Frames-1:0] due_q, due_d;
  logic [SelW-1:0]   sel_q, sel_d;

  count_t            pc_new   [Frames];
  count_t            wait_new [Frames];
  logic [Frames-1:0] due_new;
  rank_t             rank     [Frames];

  logic              best_valid;
  logic [SelW-1:0]   best_idx;
  count_t            best_wait;
  rank_t             best_rank;
  logic [SelW-1:0]   sel_pick;
  logic              picked;
  logic              sent;

  // per-frame counting
  always_comb begin
    count_t inc;
    logic   hit;
    logic   en;
    for (int i = 0; i < Frames; i++) begin
      inc = (pcount_q[i] == CountMax) ? CountMax : pcount_q[i] + count_t'(1);
      hit = (inc >= period_i[i]);
      en  = 1'b0;
      if (i < EnableBits) begin
        en = ctrl_i.frame_enable[i[1:0]];
      end
      pc_new[i]   = hit ? '0 : inc;
      due_new[i]  = due_q[i] | (hit & en);
      wait_new[i] = (due_new[i] && wait_q[i] != CountMax) ?
                    wait_q[i] + count_t'(1) : wait_q[i];
    end
  end

  // tie-break rank from the priority list
  always_comb begin
    for (int i = 0; i < Frames; i++) begin
      rank[i] = RankNone;
      for (int pos = PrioSlots - 1; pos >= 0; pos--) begin
        if (i < PrioSlots &&
            ctrl_i.priority_order[2*pos +: FrameNumW] == FrameNumW'(i)) begin
          rank[i] = RankW'(pos);
        end
      end
    end
  end

  // oldest-first search
  always_comb begin
    best_valid = 1'b0;
    best_idx   = SelNone;
    best_wait  = '0;
    best_rank  = RankNone;
    for (int i = 0; i < Frames; i++) begin
      if (due_new[i] && (!best_valid || wait_new[i] > best_wait ||
          (wait_new[i] == best_wait && rank[i] < best_rank))) begin
        best_valid = 1'b1;
        best_idx   = SelW'(i);
        best_wait  = wait_new[i];
        best_rank  = rank[i];
      end
    end
  end

  assign sel_pick = (sel_q == SelNone) ? best_idx : sel_q;
  assign picked   = (sel_pick != SelNone);
  assign sent     = picked & step_i.link_ready;

  always_comb begin
    result_o.frame_selected = picked;
    result_o.frame_number   = picked ? sel_pick[FrameNumW-1:0] : '0;
    result_o.frame_sent     = sent;
  end

  always_comb begin
    pcount_d = pcount_q;
    wait_d   = wait_q;
    due_d    = due_q;
    sel_d    = sel_q;
    if (step_i.fire) begin
      pcount_d = pc_new;
      wait_d   = wait_new;
      due_d    = due_new;
      sel_d    = sent ? SelNone : sel_pick;
      for (int i = 0; i < Frames; i++) begin
        if (sent && sel_pick == SelW'(i)) begin
          wait_d[i] = '0;
          due_d[i]  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Frames; i++) begin
        pcount_q[i] <= '0;
        wait_q[i]   <= '0;
      end
      due_q <= '0;
      sel_q <= SelNone;
    end else begin
      pcount_q <= pcount_d;
      wait_q   <= wait_d;
      due_q    <= due_d;
      sel_q    <= sel_d;
    end
  end

endmodule

### hw/rtl/periodic_frame_tx_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_frame_tx_scheduler
// Periodic frame transmit scheduler, oldest due frame first.
//
//   channel   dir  payload                                   transfer when
//   tick_i    in   link_ready                                valid & ready
//   result_o  out  frame_selected, frame_number, frame_sent  valid & ready
//   cfg_i     in   index (3b), data (8b)                     valid & ready
//
// one tick per cycle while the result is not stalled: tick register, one pass
// of counter and search logic, result register
// the frame search is a compare chain over Frames entries
// reset returns all counters, flags and the selection, and loads the
// register reset values; no clearing pass
// a stalled result holds the tick register; no further tick is taken meanwhile
// ----------------------------------------------------------------------------
module periodic_frame_tx_scheduler #(
  parameter int unsigned Frames = pfts_pkg::FramesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pfts_tick_if.sink            tick_i,
  pfts_result_if.source        result_o,
  pfts_cfg_if.sink             cfg_i
);
  import pfts_pkg::*;

  count_t   period_q [Frames];
  ctrl_t    ctrl_q;

  logic     in_valid_q;
  logic     in_link_q;
  logic     out_valid_q;
  result_t  out_q;

  logic     advance;
  logic     cfg_fire;
  step_t    step;
  result_t  core_res;

  assign advance  = in_valid_q & (~out_valid_q | result_o.ready);
  assign cfg_fire = cfg_i.valid & cfg_i.ready;

  assign tick_i.ready = ~in_valid_q | advance;
  assign cfg_i.ready  = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Frames; i++) begin
        period_q[i] <= period_reset(i);
      end
      ctrl_q.frame_enable   <= EnableRst;
      ctrl_q.priority_order <= PrioRst;
    end else if (cfg_fire) begin
      for (int i = 0; i < Frames; i++) begin
        if (i < PeriodRegs &&
            cfg_i.index == cfg_idx_t'(RegPeriod0) + cfg_idx_t'(i)) begin
          period_q[i] <= cfg_i.data;
        end
      end
      if (cfg_i.index == RegEnable) begin
        ctrl_q.frame_enable <= cfg_i.data[EnableBits-1:0];
      end
      if (cfg_i.index == RegPriority) begin
        ctrl_q.priority_order <= cfg_i.data;
      end
    end
  end

  // tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_i.valid && tick_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_link_q <= tick_i.link_ready;
    end
  end

  assign step.fire       = advance;
  assign step.link_ready = in_link_q;

  pfts_core #(
    .Frames (Frames)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .period_i (period_q),
    .ctrl_i   (ctrl_q),
    .result_o (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.frame_selected = out_q.frame_selected;
  assign result_o.frame_number   = out_q.frame_number;
  assign result_o.frame_sent     = out_q.frame_sent;

endmodule

### hw/rtl/pfts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfts_checker
// Port-level checks on the result channel of the frame scheduler.
// ----------------------------------------------------------------------------
module pfts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       frame_selected_i,
  input logic [1:0] frame_number_i,
  input logic       frame_sent_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
    $stable(frame_selected_i) && $stable(frame_number_i) && $stable(frame_sent_i))
    else $error("result changed while stalled");

  // only a selected frame can be sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_sent_i |-> frame_selected_i)
    else $error("frame sent without selection");

  // no selection reports frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !frame_selected_i |-> frame_number_i == 2'd0)
    else $error("frame number set without selection");

  // an unsent selection stays on the same frame in the next tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_ready_i && frame_selected_i && !frame_sent_i) ##1 res_valid_i
    |-> frame_selected_i && frame_number_i == $past(frame_number_i))
    else $error("selection dropped before transfer to link");

endmodule

bind periodic_frame_tx_scheduler pfts_checker u_pfts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (result_o.valid),
  .res_ready_i      (result_o.ready),
  .frame_selected_i (result_o.frame_selected),
  .frame_number_i   (result_o.frame_number),
  .frame_sent_i     (result_o.frame_sent)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic frame transmit scheduler. A directed
// table covers reset behavior, zero periods, disabling of due frames, tie
// breaks and ignored register indexes. Random phases follow, each with its own
// register settings and link-ready rate. One of these phases holds the link
// off long enough for the wait counters to saturate. Every tick transfer runs
// through a cycle-free model of the scheduler, and every result transfer is
// checked against the oldest expected result. Ticks are sent in random bursts
// and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
  import pfts_pkg::*;

  localparam int          NoFrame    = FramesDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam cfg_idx_t    RegSpare6  = 3'd6;
  localparam cfg_idx_t    RegSpare7  = 3'd7;
  localparam logic        RowTick    = 1'b0;
  localparam logic        RowCfg     = 1'b1;
  localparam logic        Untyped    = 1'b0;
  localparam logic        Typed      = 1'b1;

  typedef enum logic [1:0] {RxFree, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  typedef struct packed {
    logic      is_cfg;
    cfg_idx_t  idx;
    cfg_data_t data;
    logic      lr;
    logic      typed;
    result_t   want;
  } stim_row_t;

  localparam stim_row_t DirectedRows [26] = '{
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Typed,   '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPeriod0,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPeriod1,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Typed,   '{1'b1, 2'd1, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b1, 2'd1, 1'b1}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b1, 2'd0, 1'b1}},
    '{RowCfg,  RegEnable,   8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Typed,   '{1'b1, 2'd1, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b1, 2'd1, 1'b1}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPeriod2,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPeriod3,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegEnable,   8'hFF, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPriority, 8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Typed,   '{1'b1, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b1, 2'd0, 1'b1}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Typed,   '{1'b1, 2'd1, 1'b1}},
    '{RowCfg,  RegPriority, 8'h1B, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegSpare6,   8'hFF, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegSpare7,   8'hFF, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowCfg,  RegPeriod0,  8'hFF, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b1, Untyped, '{1'b0, 2'd0, 1'b0}},
    '{RowTick, RegPeriod0,  8'h00, 1'b0, Untyped, '{1'b0, 2'd0, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfts_tick_if   tick_if ();
  pfts_result_if res_if ();
  pfts_cfg_if    cfg_if ();

  periodic_frame_tx_scheduler dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // scheduler model state and register copies
  count_t                 period_cfg [NoFrame];
  logic [EnableBits-1:0]  enable_cfg;
  logic [2*PrioSlots-1:0] prio_cfg;
  count_t                 period_cnt [NoFrame];
  logic                   due        [NoFrame];
  count_t                 wait_cnt   [NoFrame];
  int                     chosen;

  result_t     sched_q [$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  logic        tick_on;
  result_t     got, want;

  function automatic rank_t tie_rank(input int f);
    rank_t rk;
    rk = RankNone;
    for (int s = PrioSlots - 1; s >= 0; s--) begin
      if (prio_cfg[2*s +: 2] == f) begin
        rk = rank_t'(s);
      end
    end
    return rk;
  endfunction

  task automatic apply_reg_write(input cfg_idx_t idx, input cfg_data_t d);
    case (idx)
      RegPeriod0, RegPeriod1, RegPeriod2, RegPeriod3: begin
        period_cfg[idx] = d;
      end
      RegEnable: begin
        enable_cfg = d[EnableBits-1:0];
      end
      RegPriority: begin
        prio_cfg = d;
      end
      default: begin
      end
    endcase
  endtask

  task automatic schedule_tick(input logic lr, output result_t r);
    int best;
    r = '0;
    for (int f = 0; f < NoFrame; f++) begin
      if (period_cnt[f] != CountMax) begin
        period_cnt[f]++;
      end
      if (period_cnt[f] >= period_cfg[f]) begin
        period_cnt[f] = '0;
        if (enable_cfg[f]) begin
          due[f] = 1'b1;
        end
      end
      if (due[f] && wait_cnt[f] != CountMax) begin
        wait_cnt[f]++;
      end
    end
    if (chosen == NoFrame) begin
      best = NoFrame;
      for (int f = 0; f < NoFrame; f++) begin
        if (due[f] && (best == NoFrame || wait_cnt[f] > wait_cnt[best] ||
            (wait_cnt[f] == wait_cnt[best] && tie_rank(f) < tie_rank(best)))) begin
          best = f;
        end
      end
      chosen = best;
    end
    if (chosen != NoFrame) begin
      r.frame_selected = 1'b1;
      r.frame_number   = frame_num_t'(chosen);
      if (lr) begin
        wait_cnt[chosen] = '0;
        due[chosen]      = 1'b0;
        chosen           = NoFrame;
        r.frame_sent     = 1'b1;
      end
    end
  endtask

  task automatic send_tick(input logic lr, input logic typed, input result_t typed_want);
    result_t pred;
    int unsigned gap;
    tick_if.valid      <= 1'b1;
    tick_if.link_ready <= lr;
    tick_on = 1'b1;
    do @(posedge clk_i); while (!tick_if.ready);
    schedule_tick(lr, pred);
    sched_q.push_back(typed ? typed_want : pred);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        tick_if.valid <= 1'b0;
        tick_on = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_results_done();
    if (tick_on) begin
      tick_if.valid <= 1'b0;
      tick_on = 1'b0;
    end
    while (sched_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg_write(idx, d);
  endtask

  // result side stall patterns
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    rx_mode = RxFree;
    rx_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RxFree:     res_if.ready <= 1'b1;
        RxCoin:     res_if.ready <= 1'($urandom_range(0, 1));
        RxSparse:   res_if.ready <= ($urandom_range(0, 3) == 0);
        RxPeriodic: res_if.ready <= (rx_left[2:0] != 3'd0);
        default:    res_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.frame_selected, res_if.frame_number, res_if.frame_sent};
      if (sched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: sel=%0d num=%0d sent=%0d",
                   got.frame_selected, got.frame_number, got.frame_sent);
        end
      end else begin
        want = sched_q.pop_front();
        if (got.frame_selected !== want.frame_selected ||
            got.frame_number !== want.frame_number ||
            got.frame_sent !== want.frame_sent) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected sel=%0d num=%0d sent=%0d, got sel=%0d num=%0d sent=%0d",
                     want.frame_selected, want.frame_number, want.frame_sent,
                     got.frame_selected, got.frame_number, got.frame_sent);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    cfg_data_t   period_val;
    cfg_data_t   prio_val;
    cfg_data_t   enable_val;
    int unsigned n_ticks;
    int unsigned ready_pct;
    tick_if.valid      <= 1'b0;
    tick_if.link_ready <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= RegPeriod0;
    cfg_if.data        <= '0;
    mismatches = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    tick_on    = 1'b0;
    for (int f = 0; f < NoFrame; f++) begin
      period_cfg[f] = PeriodRstRest;
      period_cnt[f] = '0;
      due[f]        = 1'b0;
      wait_cnt[f]   = '0;
    end
    period_cfg[0] = PeriodRst0;
    period_cfg[1] = PeriodRst1;
    enable_cfg    = EnableRst;
    prio_cfg      = PrioRst;
    chosen        = NoFrame;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirectedRows); i++) begin
      if (DirectedRows[i].is_cfg) begin
        wait_results_done();
        write_reg(DirectedRows[i].idx, DirectedRows[i].data);
        if (i + 1 == $size(DirectedRows) || !DirectedRows[i+1].is_cfg) begin
          cfg_if.valid <= 1'b0;
        end
      end else begin
        send_tick(DirectedRows[i].lr, DirectedRows[i].typed, DirectedRows[i].want);
      end
    end

    // random phases; phase 1 holds the link off so wait counters saturate
    for (int ph = 0; ph < 9; ph++) begin
      wait_results_done();
      for (int f = 0; f < PeriodRegs; f++) begin
        case (ph)
          0: period_val = '0;
          1: period_val = cfg_data_t'($urandom_range(1, 4));
          2: period_val = f[0] ? cfg_data_t'($urandom_range(0, 1)) : CountMax;
          default: period_val = ($urandom_range(0, 5) == 0) ? cfg_data_t'($urandom)
                                                            : cfg_data_t'($urandom_range(0, 12));
        endcase
        write_reg(cfg_idx_t'(f), period_val);
      end
      enable_val = (ph < 3) ? 8'hFF : (ph == 3) ? 8'h00 : cfg_data_t'($urandom);
      prio_val   = (ph == 0) ? 8'hFF : (ph == 2) ? 8'h00 : cfg_data_t'($urandom);
      write_reg(RegEnable, enable_val);
      write_reg(RegPriority, prio_val);
      if (ph % 3 == 2) begin
        write_reg((ph % 2 == 1) ? RegSpare7 : RegSpare6, cfg_data_t'($urandom));
      end
      cfg_if.valid <= 1'b0;
      n_ticks   = (ph == 1) ? 280 : (ph == 0) ? 60 : (ph == 2) ? 40 : 55;
      ready_pct = (ph == 1) ? 1 : $urandom_range(0, 100);
      repeat (n_ticks) begin
        send_tick($urandom_range(0, 99) < ready_pct, Untyped, '0);
      end
    end

    wait_results_done();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && sched_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### periodic_frame_tx_scheduler.f
hw/rtl/pfts_pkg.sv
hw/rtl/pfts_if.sv
hw/rtl/pfts_core.sv
hw/rtl/periodic_frame_tx_scheduler.sv
hw/rtl/pfts_checker.sv
tb/sv/testbench.sv
